// ===== rtl/photopeak_compton_event_classifier_macros.svh =====
// assertion macros for the event classifier
// included by modules that carry concurrent checks; no other dependencies
`ifndef PHOTOPEAK_COMPTON_EVENT_CLASSIFIER_MACROS_SVH
`define PHOTOPEAK_COMPTON_EVENT_CLASSIFIER_MACROS_SVH

// same-cycle implication, checks off while reset is held
`define PCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("classifier check failed");

// next-cycle implication
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("classifier check failed");

`endif

// ===== rtl/pcec_pkg.sv =====
// shared types and constants for the photopeak / compton event classifier
// no dependencies
package pcec_pkg;

    localparam int unsigned E_W   = 18;
    localparam int unsigned IDX_W = 8;
    localparam int unsigned CNT_W = 8;

    localparam int unsigned APB_DW = 32;
    localparam int unsigned APB_AW = 5;

    typedef enum logic [1:0] {
        KIND_PEAK_HIGH = 2'd0,
        KIND_PEAK_LOW  = 2'd1,
        KIND_COMPTON   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_WIN_HIGH_LO = 3'd0,
        REG_WIN_HIGH_HI = 3'd1,
        REG_WIN_LOW_LO  = 3'd2,
        REG_WIN_LOW_HI  = 3'd3,
        REG_HIT_THR     = 3'd4
    } t_reg_idx;

    localparam logic [E_W-1:0] RST_WIN_HIGH_LO = 18'd26188;
    localparam logic [E_W-1:0] RST_WIN_HIGH_HI = 18'd30132;
    localparam logic [E_W-1:0] RST_WIN_LOW_LO  = 18'd12564;
    localparam logic [E_W-1:0] RST_WIN_LOW_HI  = 18'd15340;
    localparam logic [E_W-1:0] RST_HIT_THR     = 18'd64;

    typedef struct packed {
        logic [E_W-1:0]   crystal_energy;
        logic             last_crystal;
        logic [IDX_W-1:0] scatter_crystal;
        logic             scatter_known;
        logic [CNT_W-1:0] compton_count;
        logic [CNT_W-1:0] photo_count;
        logic             compton_tag;
    } t_item;

    typedef struct packed {
        t_kind            event_kind;
        logic [IDX_W-1:0] crystal_a;
        logic [IDX_W-1:0] crystal_b;
        logic [E_W-1:0]   energy_a;
        logic [E_W-1:0]   energy_b;
    } t_result;

endpackage

// ===== rtl/photopeak_compton_event_classifier.sv =====
// photopeak / compton event classifier, top level
// depends on pcec_pkg and photopeak_compton_event_classifier_macros.svh
//
// Takes one crystal request per clock, in crystal order, and on the request
// marked last reports at most one result: a 440 keV photopeak, else a 218 keV
// photopeak, else a compton scatter/absorber pair. A request is held in an
// input register until it is processed, then a single short stage of compares
// updates the running maximum and hit tracking and loads the result register,
// so a result passes the input register and then the result register, which
// holds it while the output stalls. Throughput is one request per cycle; the
// input stalls only when a last request finds the result register full and
// stalled. Windows and threshold are set through the APB port at byte
// addresses 0, 4, 8, 12, 16 and should change only while the block is idle.
`include "photopeak_compton_event_classifier_macros.svh"

module photopeak_compton_event_classifier
    import pcec_pkg::*;
#(
    parameter int unsigned NUM_CRYSTALS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // crystal requests
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_item               i_in,
    // results
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_result             o_out,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int unsigned CW = $clog2(NUM_CRYSTALS + 1);

    // configuration registers
    logic [E_W-1:0] r_win_high_lo, r_win_high_hi, r_win_low_lo, r_win_low_hi, r_hit_thr;
    t_reg_idx       cfg_idx;
    logic           cfg_wr;

    // input stage
    logic  r_in_valid;
    t_item r_in;

    // event tracking
    logic [CW-1:0]    r_count;
    logic [E_W-1:0]   r_max_e;
    logic [IDX_W-1:0] r_max_idx;
    logic             r_max_found;
    logic [IDX_W-1:0] r_first_idx, r_second_idx;
    logic [E_W-1:0]   r_first_e, r_second_e;
    logic [1:0]       r_tally;

    logic [CW-1:0]    n_count;
    logic [E_W-1:0]   n_max_e;
    logic [IDX_W-1:0] n_max_idx;
    logic             n_max_found;
    logic [IDX_W-1:0] n_first_idx, n_second_idx;
    logic [E_W-1:0]   n_first_e, n_second_e;
    logic [1:0]       n_tally;

    // result stage
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    produced;

    logic              in_range, is_hit, pair_ok, first_is_scatter, second_is_scatter;
    logic              in_high, in_low;
    logic [CW+IDX_W-1:0] count_ext;
    logic [IDX_W-1:0]  idx;
    logic              out_free, proc_fire, accept;

    // ---------------------------------------------------------------- apb
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_high_lo <= RST_WIN_HIGH_LO;
            r_win_high_hi <= RST_WIN_HIGH_HI;
            r_win_low_lo  <= RST_WIN_LOW_LO;
            r_win_low_hi  <= RST_WIN_LOW_HI;
            r_hit_thr     <= RST_HIT_THR;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIN_HIGH_LO: r_win_high_lo <= pwdata[E_W-1:0];
                REG_WIN_HIGH_HI: r_win_high_hi <= pwdata[E_W-1:0];
                REG_WIN_LOW_LO:  r_win_low_lo  <= pwdata[E_W-1:0];
                REG_WIN_LOW_HI:  r_win_low_hi  <= pwdata[E_W-1:0];
                REG_HIT_THR:     r_hit_thr     <= pwdata[E_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIN_HIGH_LO: prdata = APB_DW'(r_win_high_lo);
            REG_WIN_HIGH_HI: prdata = APB_DW'(r_win_high_hi);
            REG_WIN_LOW_LO:  prdata = APB_DW'(r_win_low_lo);
            REG_WIN_LOW_HI:  prdata = APB_DW'(r_win_low_hi);
            REG_HIT_THR:     prdata = APB_DW'(r_hit_thr);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- flow
    assign out_free   = !r_out_valid || !i_out_stall;
    // only a last request needs room in the result register
    assign proc_fire  = r_in_valid && (!r_in.last_crystal || out_free);
    assign o_in_stall = r_in_valid && !proc_fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
    end

    // ---------------------------------------------------------------- tracking
    assign in_range  = r_count < CW'(NUM_CRYSTALS);
    // crystal number modulo 256
    assign count_ext = {{IDX_W{1'b0}}, r_count};
    assign idx       = count_ext[IDX_W-1:0];
    assign is_hit    = in_range && (r_in.crystal_energy > r_hit_thr);

    always_comb begin
        n_count      = r_count;
        n_max_e      = r_max_e;
        n_max_idx    = r_max_idx;
        n_max_found  = r_max_found;
        n_first_idx  = r_first_idx;
        n_first_e    = r_first_e;
        n_second_idx = r_second_idx;
        n_second_e   = r_second_e;
        n_tally      = r_tally;
        if (in_range) begin
            n_count = r_count + 1'b1;
            // strict compare keeps the first crystal on ties
            if (r_in.crystal_energy > r_max_e) begin
                n_max_e     = r_in.crystal_energy;
                n_max_idx   = idx;
                n_max_found = 1'b1;
            end
        end
        if (is_hit) begin
            case (r_tally)
                2'd0: begin
                    n_first_idx = idx;
                    n_first_e   = r_in.crystal_energy;
                    n_tally     = 2'd1;
                end
                2'd1: begin
                    n_second_idx = idx;
                    n_second_e   = r_in.crystal_energy;
                    n_tally      = 2'd2;
                end
                default: n_tally = 2'd3;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_max_e      <= '0;
            r_max_idx    <= '0;
            r_max_found  <= 1'b0;
            r_first_idx  <= '0;
            r_first_e    <= '0;
            r_second_idx <= '0;
            r_second_e   <= '0;
            r_tally      <= '0;
        end else if (proc_fire) begin
            if (r_in.last_crystal) begin
                r_count      <= '0;
                r_max_e      <= '0;
                r_max_idx    <= '0;
                r_max_found  <= 1'b0;
                r_first_idx  <= '0;
                r_first_e    <= '0;
                r_second_idx <= '0;
                r_second_e   <= '0;
                r_tally      <= '0;
            end else begin
                r_count      <= n_count;
                r_max_e      <= n_max_e;
                r_max_idx    <= n_max_idx;
                r_max_found  <= n_max_found;
                r_first_idx  <= n_first_idx;
                r_first_e    <= n_first_e;
                r_second_idx <= n_second_idx;
                r_second_e   <= n_second_e;
                r_tally      <= n_tally;
            end
        end
    end

    // ---------------------------------------------------------------- classify
    assign in_high = n_max_found && (n_max_e >= r_win_high_lo) && (n_max_e <= r_win_high_hi);
    assign in_low  = n_max_found && (n_max_e >= r_win_low_lo) && (n_max_e <= r_win_low_hi);
    assign pair_ok = (n_tally == 2'd2) && r_in.scatter_known
                     && (r_in.compton_count == CNT_W'(1)) && (r_in.photo_count == '0)
                     && r_in.compton_tag;
    assign first_is_scatter  = n_first_idx == r_in.scatter_crystal;
    assign second_is_scatter = n_second_idx == r_in.scatter_crystal;

    always_comb begin
        n_out            = '0;
        n_out.event_kind = KIND_PEAK_HIGH;
        produced         = 1'b0;
        if (in_high) begin
            n_out.crystal_a = n_max_idx;
            n_out.energy_a  = n_max_e;
            produced        = 1'b1;
        end else if (in_low) begin
            n_out.event_kind = KIND_PEAK_LOW;
            n_out.crystal_a  = n_max_idx;
            n_out.energy_a   = n_max_e;
            produced         = 1'b1;
        end else if (pair_ok && first_is_scatter) begin
            n_out.event_kind = KIND_COMPTON;
            n_out.crystal_a  = n_first_idx;
            n_out.crystal_b  = n_second_idx;
            n_out.energy_a   = n_first_e;
            n_out.energy_b   = n_second_e;
            produced         = 1'b1;
        end else if (pair_ok && second_is_scatter) begin
            n_out.event_kind = KIND_COMPTON;
            n_out.crystal_a  = n_second_idx;
            n_out.crystal_b  = n_first_idx;
            n_out.energy_a   = n_second_e;
            n_out.energy_b   = n_first_e;
            produced         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_in.last_crystal && produced) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && r_in.last_crystal && produced) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------- checks
    `PCC_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n,
        o_in_stall, r_in_valid && r_in.last_crystal)
    `PCC_ASSERT_NEXT(a_event_cleared, i_clk, i_rst_n,
        proc_fire && r_in.last_crystal, r_tally == '0 && r_count == '0 && !r_max_found)
    `PCC_ASSERT_NOW(a_peak_b_zero, i_clk, i_rst_n,
        r_out_valid && r_out.event_kind != KIND_COMPTON,
        r_out.crystal_b == '0 && r_out.energy_b == '0)
    `PCC_ASSERT_NOW(a_pair_above_thr, i_clk, i_rst_n,
        r_out_valid && r_out.event_kind == KIND_COMPTON,
        r_out.energy_a > r_hit_thr && r_out.energy_b > r_hit_thr)

endmodule
